// ===== rtl/rrip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_pkg: shared types and constants for the rrip set replacement block
// re-reference prediction value type, bounds and operation codes
// ----------------------------------------------------------------------------
package rrip_pkg;

  localparam int RrpvW = 3;
  localparam int WayFieldW = 4;
  // wide enough to compare a way field against any set size up to 64
  localparam int WayCmpW = 7;

  typedef logic [RrpvW-1:0] rrpv_t;
  typedef logic [WayFieldW-1:0] way_field_t;

  localparam rrpv_t RrpvMax = rrpv_t'(7);
  localparam rrpv_t RrpvMin = rrpv_t'(0);

  typedef enum logic {
    OpUpdate = 1'b0,
    OpVictim = 1'b1
  } opcode_e;

endpackage

// ===== rtl/rrip_victim_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_victim_sel: maximum prediction value and lowest way holding it
// value-presence vectors, priority over eight values, lowest-set-bit encode
// ----------------------------------------------------------------------------
module rrip_victim_sel #(
  parameter int WAYS = 16,
  parameter int WayIdxW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  rrip_pkg::rrpv_t    rrpv_i [WAYS],
  output rrip_pkg::rrpv_t    max_o,
  output logic [WayIdxW-1:0] victim_o
);
  import rrip_pkg::*;

  localparam int NumVals = 1 << RrpvW;

  logic [WAYS-1:0]    is_val [NumVals];
  logic [NumVals-1:0] present;
  logic [WAYS-1:0]    at_max;
  logic [WAYS-1:0]    first_oh;

  always_comb begin
    for (int v = 0; v < NumVals; v++) begin
      for (int w = 0; w < WAYS; w++) begin
        is_val[v][w] = (rrpv_i[w] == rrpv_t'(v));
      end
      present[v] = |is_val[v];
    end
  end

  // highest value present in the set
  always_comb begin
    max_o = RrpvMin;
    for (int v = 0; v < NumVals; v++) begin
      if (present[v]) begin
        max_o = rrpv_t'(v);
      end
    end
  end

  // isolate the lowest way at the maximum
  assign at_max   = is_val[max_o];
  assign first_oh = at_max & (~at_max + WAYS'(1));

  always_comb begin
    victim_o = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (first_oh[w]) begin
        victim_o = victim_o | WayIdxW'(w);
      end
    end
  end

endmodule

// ===== rtl/rrip_set_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_set_replacement: 3-bit rrip replacement state for one cache set
// per-way prediction values with update, victim selection and set aging
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) carries one request per beat:
//   operation_i selects an update of way_i (friendly_i: 1 writes 0, 0 writes 7)
//   or a victim request, which returns the lowest way at 7 after aging the
//   whole set by (7 - max) when no way holds 7
//   output channel (out_valid_o / out_stall_i) returns exactly one result beat
//   per request: victim_way_o / victim_valid_o for victim requests, way_error_o
//   for an update naming a way at or above WAYS (no entry changes then)
//   a request passes one input register and one result register with
//   single-pass logic between them; throughput: one beat per cycle while
//   out_stall_i is low; the per-way value vectors and one priority pick over
//   eight values set the depth of the path between the registers
//   a stalled result holds in the result register; the input register keeps
//   filling while the result register drains, and in_stall_o rises only when
//   both hold a beat and out_stall_i is high
//   reset: all ways return to 7 and both pipeline stages empty
// ----------------------------------------------------------------------------
module rrip_set_replacement #(
  parameter int WAYS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rrip_pkg::opcode_e      operation_i,
  input  rrip_pkg::way_field_t   way_i,
  input  logic                   friendly_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rrip_pkg::way_field_t   victim_way_o,
  output logic                   victim_valid_o,
  output logic                   way_error_o
);
  import rrip_pkg::*;

  localparam int WayIdxW = (WAYS > 1) ? $clog2(WAYS) : 1;

  // input register stage
  logic       s1_valid_q;
  opcode_e    s1_op_q;
  way_field_t s1_way_q;
  logic       s1_friendly_q;

  // result register stage
  logic       out_valid_q;
  way_field_t victim_way_q;
  logic       victim_valid_q;
  logic       way_error_q;

  // prediction values, one per way
  rrpv_t rrpv_q [WAYS];
  rrpv_t rrpv_d [WAYS];

  logic                     advance;
  logic                     fire;
  logic                     in_fire;
  logic                     is_victim;
  logic                     way_err;
  rrpv_t                    top;
  rrpv_t                    lift;
  logic [WayIdxW-1:0]       victim_idx;
  logic [WayIdxW+WayFieldW-1:0] victim_ext;
  logic                     any_max;

  // result register can take a new beat when empty or draining
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q       <= operation_i;
      s1_way_q      <= way_i;
      s1_friendly_q <= friendly_i;
    end
  end

  // victim pick over the current values
  rrip_victim_sel #(
    .WAYS    (WAYS),
    .WayIdxW (WayIdxW)
  ) u_victim_sel (
    .rrpv_i   (rrpv_q),
    .max_o    (top),
    .victim_o (victim_idx)
  );

  assign is_victim = (s1_op_q == OpVictim);
  assign way_err   = !is_victim &&
                     ({{(WayCmpW-WayFieldW){1'b0}}, s1_way_q} >= WayCmpW'(WAYS));
  // lift is zero when some way already holds the maximum
  assign lift      = RrpvMax - top;
  assign victim_ext = {{WayFieldW{1'b0}}, victim_idx};

  // next values: aging on a victim request, a single write on a valid update
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rrpv_d[w] = rrpv_q[w];
      if (is_victim) begin
        // values never exceed the maximum, so the sum stays within 7
        rrpv_d[w] = rrpv_t'(rrpv_q[w] + lift);
      end else if ({{(WayCmpW-WayFieldW){1'b0}}, s1_way_q} == WayCmpW'(w)) begin
        rrpv_d[w] = s1_friendly_q ? RrpvMin : RrpvMax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WAYS; w++) begin
        rrpv_q[w] <= RrpvMax;
      end
    end else if (fire) begin
      rrpv_q <= rrpv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      victim_way_q   <= is_victim ? victim_ext[WayFieldW-1:0] : '0;
      victim_valid_q <= is_victim;
      way_error_q    <= way_err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign victim_way_o   = victim_way_q;
  assign victim_valid_o = victim_valid_q;
  assign way_error_o    = way_error_q;

  // some way holds the maximum value
  always_comb begin
    any_max = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      any_max = any_max | (rrpv_q[w] == RrpvMax);
    end
  end

  // after a victim beat is processed the set always holds a way at 7
  a_victim_leaves_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_victim) |=> any_max)
    else $error("no way at maximum after victim request");

  // input side stalls only when both the input and result registers are occupied
  a_stall_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with an empty pipeline");

  // a result never flags both a victim and a way error
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(victim_valid_q && way_error_q))
    else $error("victim and way error in one result");

  // update results carry a zero victim index
  a_update_zero_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !victim_valid_q) |-> (victim_way_q == '0))
    else $error("nonzero victim way on an update result");

endmodule
